// File: rtl/itda_pkg.sv
// itda_pkg: widths, digit count and character codes for the decimal ASCII unit.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package itda_pkg;

    localparam int VALUE_WIDTH = 32;
    // decimal digits of 2^W-1: floor(W*log10(2)) + 1, log10(2) ~ 1233/4096
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_WIDTH   = NUM_DIGITS * 4;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W      = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // finished conversion handed from converter to emitter
    typedef struct packed {
        logic                 neg;
        logic [BCD_WIDTH-1:0] bcd;
    } t_conv_res;

endpackage

// File: rtl/itda_in_if.sv
// itda_in_if: input channel, one binary word and its signedness flag.
// Depends on itda_pkg.
`timescale 1ns / 1ps

interface itda_in_if;
    import itda_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_signed;

    modport source (output valid, output value, output is_signed, input ready);
    modport sink   (input valid, input value, input is_signed, output ready);
endinterface

// File: rtl/itda_out_if.sv
// itda_out_if: output channel, one ASCII character and its last flag.
// Depends on itda_pkg.
`timescale 1ns / 1ps

interface itda_out_if;
    import itda_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;
    logic       last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// File: rtl/int_to_decimal_ascii_unit.sv
// int_to_decimal_ascii_unit: top level, binary word to decimal ASCII text.
// Depends on itda_pkg, itda_in_if, itda_out_if, itda_dabble, itda_emit.
//
//   channel | dir | words                      | fields
//   i_in    | in  | one per number             | value[VALUE_WIDTH], is_signed
//   o_out   | out | 1..NUM_DIGITS+1 per number | ascii_char[8], last
//
// Conversion shifts one bit per cycle through the shift-and-add-3 register, between an
// accept state and a hand-off state. Emission takes the hand-off, drops each leading zero,
// leaves the zero skip, then sends the sign and each digit, one word per cycle while o_out
// is not stalled. It overlaps the conversion of the next number.
// Synchronous active-low reset clears control state only; no item state is kept.
// A stall on o_out holds the output register; the converter keeps running and waits
// with its result until the emitter is free.
`timescale 1ns / 1ps

module int_to_decimal_ascii_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itda_in_if.sink     i_in,
    itda_out_if.source  o_out
);
    import itda_pkg::*;

    t_conv_res conv_res;
    logic      conv_valid;
    logic      conv_ready;

    // bit-serial binary to BCD, magnitude and sign formed at accept
    itda_dabble u_dabble (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res       (conv_res),
        .o_res_valid (conv_valid),
        .i_res_ready (conv_ready)
    );

    // digit-serial text out, most significant first, with output register
    itda_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (conv_res),
        .i_res_valid (conv_valid),
        .o_res_ready (conv_ready),
        .o_out       (o_out)
    );
endmodule

// File: rtl/itda_dabble.sv
// itda_dabble: bit-serial shift-and-add-3 converter, binary magnitude to BCD.
// Depends on itda_pkg and itda_in_if.
`timescale 1ns / 1ps

module itda_dabble (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    itda_in_if.sink              i_in,
    output itda_pkg::t_conv_res  o_res,
    output logic                 o_res_valid,
    input  logic                 i_res_ready
);
    import itda_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_WIDTH-1:0]   r_bcd, n_bcd;
    logic                   r_neg, n_neg;
    logic [BCD_WIDTH-1:0]   adj;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;

    assign in_neg = i_in.is_signed & i_in.value[VALUE_WIDTH-1];
    assign in_mag = in_neg ? (~i_in.value + VALUE_WIDTH'(1)) : i_in.value;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_bin   = in_mag;
                    n_neg   = in_neg;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {adj[BCD_WIDTH-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_HOLD);
    assign o_res.neg   = r_neg;
    assign o_res.bcd   = r_bcd;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_cnt < CNT_W'(VALUE_WIDTH)))
        else $error("shift count overran the word width");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_CONV) && (r_cnt == '0))
        else $error("accepted word did not start a conversion");

    a_top_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> (r_bcd[BCD_WIDTH-1 -: 4] <= 4'd9))
        else $error("top BCD digit out of range");
endmodule

// File: rtl/itda_emit.sv
// itda_emit: drops leading zeros, sends sign and digits one word per cycle while o_out is not stalled.
// Depends on itda_pkg and itda_out_if.
`timescale 1ns / 1ps

module itda_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itda_pkg::t_conv_res  i_res,
    input  logic                 i_res_valid,
    output logic                 o_res_ready,
    itda_out_if.source           o_out
);
    import itda_pkg::*;

    localparam logic [1:0] E_IDLE  = 2'd0;
    localparam logic [1:0] E_SKIP  = 2'd1;
    localparam logic [1:0] E_SIGN  = 2'd2;
    localparam logic [1:0] E_DIGIT = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [BCD_WIDTH-1:0] r_bcd, n_bcd;
    logic                 r_neg, n_neg;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic                 r_ovalid, n_ovalid;
    logic [7:0]           r_char, n_char;
    logic                 r_last, n_last;
    logic                 slot_free;
    logic [3:0]           top;

    assign slot_free = !r_ovalid || o_out.ready;
    assign top       = r_bcd[BCD_WIDTH-1 -: 4];

    always_comb begin
        n_state  = r_state;
        n_bcd    = r_bcd;
        n_neg    = r_neg;
        n_left   = r_left;
        n_ovalid = r_ovalid && !o_out.ready;
        n_char   = r_char;
        n_last   = r_last;
        case (r_state)
            E_IDLE: begin
                if (i_res_valid) begin
                    n_bcd   = i_res.bcd;
                    n_neg   = i_res.neg;
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = E_SKIP;
                end
            end
            E_SKIP: begin
                // zero keeps its final digit
                if ((top == 4'd0) && (r_left != LEFT_W'(1))) begin
                    n_bcd  = {r_bcd[BCD_WIDTH-5:0], 4'd0};
                    n_left = r_left - LEFT_W'(1);
                end else begin
                    n_state = r_neg ? E_SIGN : E_DIGIT;
                end
            end
            E_SIGN: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_MINUS;
                    n_last   = 1'b0;
                    n_state  = E_DIGIT;
                end
            end
            E_DIGIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_ZERO + {4'd0, top};
                    n_last   = (r_left == LEFT_W'(1));
                    n_bcd    = {r_bcd[BCD_WIDTH-5:0], 4'd0};
                    n_left   = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state = E_IDLE;
                    end
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_ovalid <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_left   <= n_left;
        end
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_res_ready      = (r_state == E_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.ascii_char = r_char;
    assign o_out.last       = r_last;

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == E_DIGIT) || (r_state == E_SKIP)) |-> (r_left != '0))
        else $error("digit count ran out while emitting");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == E_DIGIT) && slot_free && (r_left == LEFT_W'(1))) |=> (r_state == E_IDLE)
            && r_last)
        else $error("final digit did not close the number");

    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ((r_char == CHAR_MINUS) || ((r_char >= CHAR_ZERO) && (r_char <= CHAR_NINE))))
        else $error("character outside sign and digit codes");
endmodule
